/* rtl/trc_pkg.sv */
// ----------------------------------------------------------------------------
// trc_pkg
// Types, opcodes and sizes shared by the register CPU execute block.
// ----------------------------------------------------------------------------
package trc_pkg;

   localparam int ADDR_BITS    = 16;
   localparam int NUM_REGS     = 4;
   localparam int REG_IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int WORD_BITS    = 32;
   localparam int MD_STEPS     = WORD_BITS;
   localparam int MD_CNT_BITS  = $clog2(MD_STEPS);

   // opcodes
   localparam logic [4:0] OP_NOP     = 5'd0;
   localparam logic [4:0] OP_HALT    = 5'd1;
   localparam logic [4:0] OP_MOV_RR  = 5'd2;
   localparam logic [4:0] OP_MOV_RM  = 5'd3;
   localparam logic [4:0] OP_MOV_MR  = 5'd4;
   localparam logic [4:0] OP_MOV_RI  = 5'd5;
   localparam logic [4:0] OP_MOV_MI  = 5'd6;
   localparam logic [4:0] OP_ADD     = 5'd7;
   localparam logic [4:0] OP_SUB     = 5'd8;
   localparam logic [4:0] OP_CMP     = 5'd9;
   localparam logic [4:0] OP_JMP     = 5'd10;
   localparam logic [4:0] OP_JZ      = 5'd11;
   localparam logic [4:0] OP_JG      = 5'd12;
   localparam logic [4:0] OP_JL      = 5'd13;
   localparam logic [4:0] OP_OUT     = 5'd14;
   localparam logic [4:0] OP_INC     = 5'd15;
   localparam logic [4:0] OP_DEC     = 5'd16;
   localparam logic [4:0] OP_MUL     = 5'd17;
   localparam logic [4:0] OP_DIV     = 5'd18;

   // fault codes
   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_ILLEGAL = 2'd1;
   localparam logic [1:0] FAULT_DIV0    = 2'd2;
   localparam logic [1:0] FAULT_OUT_REG = 2'd3;

   localparam logic [31:0] OUT_MAX_REG = 32'd3;

   typedef struct packed {
      logic [4:0]  func;
      logic [31:0] op_a;
      logic [31:0] op_b;
      logic [31:0] mem_data;
      logic        resume;
   } req_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic               mem_write;
      logic [15:0]        write_addr;
      logic [31:0]        write_data;
      logic               out_valid;
      logic [1:0]         out_reg;
      logic signed [31:0] out_value;
      logic               halted;
      logic [1:0]         fault;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic                 is_div;
      logic [WORD_BITS-1:0] opnd_a;
      logic [WORD_BITS-1:0] opnd_b;
   } md_req_type;

   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] result;
   } md_rsp_type;

endpackage

/* rtl/trc_req_if.sv */
// ----------------------------------------------------------------------------
// trc_req_if
// Instruction channel: valid/ready with one fetched instruction as payload.
// ----------------------------------------------------------------------------
interface trc_req_if;
   import trc_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/trc_rsp_if.sv */
// ----------------------------------------------------------------------------
// trc_rsp_if
// Result channel: valid/ready with one execute result as payload.
// ----------------------------------------------------------------------------
interface trc_rsp_if;
   import trc_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/trc_csr_if.sv */
// ----------------------------------------------------------------------------
// trc_csr_if
// Register write channel: valid/ready with the start address as data.
// ----------------------------------------------------------------------------
interface trc_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/trc_muldiv.sv */
// ----------------------------------------------------------------------------
// trc_muldiv
// Iterative multiply / signed divide, one bit per cycle on a shared adder.
// ----------------------------------------------------------------------------
module trc_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  trc_pkg::md_req_type md_req,
   output trc_pkg::md_rsp_type md_rsp
);
   import trc_pkg::*;

   typedef enum logic [1:0] {MD_IDLE, MD_RUN, MD_DONE} md_state_type;

   md_state_type           state_ff;
   logic [MD_CNT_BITS-1:0] count_ff;
   logic                   is_div_ff;
   logic                   neg_ff;
   logic [WORD_BITS:0]     acc_ff;   // product or partial remainder
   logic [WORD_BITS-1:0]   x_ff;     // multiplicand or quotient
   logic [WORD_BITS-1:0]   y_ff;     // multiplier or divisor

   logic [WORD_BITS-1:0]   abs_a;
   logic [WORD_BITS-1:0]   abs_b;
   logic [WORD_BITS:0]     rem_sh;
   logic [WORD_BITS:0]     add_a;
   logic [WORD_BITS:0]     add_b;
   logic [WORD_BITS+1:0]   opnd_b_ext;
   logic [WORD_BITS+1:0]   sum;
   logic                   no_borrow;
   logic [WORD_BITS:0]     acc_in;
   logic [WORD_BITS-1:0]   x_in;
   logic [WORD_BITS-1:0]   y_in;

   always_comb begin
      abs_a = md_req.opnd_a[WORD_BITS-1] ? WORD_BITS'(0) - md_req.opnd_a : md_req.opnd_a;
      abs_b = md_req.opnd_b[WORD_BITS-1] ? WORD_BITS'(0) - md_req.opnd_b : md_req.opnd_b;
      rem_sh = {acc_ff[WORD_BITS-1:0], x_ff[WORD_BITS-1]};
      // one adder serves both: add for multiply, subtract for divide
      add_a = is_div_ff ? rem_sh : acc_ff;
      add_b = is_div_ff ? {1'b0, y_ff} : {1'b0, (y_ff[0] ? x_ff : '0)};
      opnd_b_ext = is_div_ff ? ~{1'b0, add_b} : {1'b0, add_b};
      sum = {1'b0, add_a} + opnd_b_ext + (WORD_BITS+2)'(is_div_ff);
      no_borrow = ~sum[WORD_BITS+1];
      if (is_div_ff) begin
         acc_in = no_borrow ? sum[WORD_BITS:0] : rem_sh;
         x_in   = {x_ff[WORD_BITS-2:0], no_borrow};
         y_in   = y_ff;
      end else begin
         acc_in = {1'b0, sum[WORD_BITS-1:0]};
         x_in   = {x_ff[WORD_BITS-2:0], 1'b0};
         y_in   = {1'b0, y_ff[WORD_BITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            MD_IDLE: begin
               if (md_req.start) begin
                  state_ff  <= MD_RUN;
                  count_ff  <= '0;
                  is_div_ff <= md_req.is_div;
                  neg_ff    <= md_req.opnd_a[WORD_BITS-1] ^ md_req.opnd_b[WORD_BITS-1];
                  acc_ff    <= '0;
                  x_ff      <= md_req.is_div ? abs_a : md_req.opnd_a;
                  y_ff      <= md_req.is_div ? abs_b : md_req.opnd_b;
               end
            end
            MD_RUN: begin
               acc_ff   <= acc_in;
               x_ff     <= x_in;
               y_ff     <= y_in;
               count_ff <= count_ff + MD_CNT_BITS'(1);
               if (count_ff == MD_CNT_BITS'(MD_STEPS - 1)) begin
                  state_ff <= MD_DONE;
               end
            end
            MD_DONE: begin
               state_ff <= MD_IDLE;
            end
            default: begin
               state_ff <= MD_IDLE;
            end
         endcase
      end
   end

   assign md_rsp.done   = (state_ff == MD_DONE);
   assign md_rsp.result = is_div_ff ? (neg_ff ? WORD_BITS'(0) - x_ff : x_ff)
                                    : acc_ff[WORD_BITS-1:0];

endmodule

/* rtl/toy_register_cpu_execute.sv */
// ----------------------------------------------------------------------------
// toy_register_cpu_execute
// Execute stage of a small four-register CPU with iterative multiply/divide.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one fetched instruction per transfer (opcode, the two
//   following words, the memory word at op_b's address, resume flag).
//   rsp_ch returns exactly one result per instruction, in order: next fetch
//   address, optional memory write, optional OUT value, halt and fault.
//   csr_ch writes the start address; it is always ready and is picked up
//   only by the first instruction after reset.
// Sequencing:
//   most instructions pass through the execute state, the result register
//   and the output register. MUL and DIV wait between execute and the
//   result register for trc_muldiv, whose 32 one-bit steps of the shared
//   adder lie between its start and done states.
//   req_ch is ready only while no instruction is in progress, so a new
//   request is taken only after the previous result reaches the output register.
// Reset:
//   registers, compare flag and program counter clear; the start address
//   register clears to zero.
// Stall:
//   a result held by a stalled receiver does not block the next request;
//   a following result waits internally until the output register frees.
// ----------------------------------------------------------------------------
module toy_register_cpu_execute (
   input logic       clock,
   input logic       reset,
   trc_req_if.sink   req_ch,
   trc_rsp_if.source rsp_ch,
   trc_csr_if.sink   csr_ch
);
   import trc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT, ST_FINISH} state_type;

   state_type            state_ff;
   logic [ADDR_BITS-1:0] pc_ff;
   logic                 load_pend_ff;
   logic [15:0]          start_pc_ff;
   logic [31:0]          regs_ff [NUM_REGS];
   logic [31:0]          cmp_ff;
   req_type              in_ff;
   rsp_type              res_ff;
   rsp_type              rsp_data_ff;
   logic                 rsp_valid_ff;

   md_req_type           md_req;
   md_rsp_type           md_rsp;

   logic [ADDR_BITS-1:0] pc_cur;
   logic [ADDR_BITS-1:0] npc;
   logic                 a_ok;
   logic                 b_ok;
   logic [31:0]          ra;
   logic [31:0]          rb;
   logic                 wr_en;
   logic [31:0]          wr_data;
   logic                 cmp_wr;
   logic                 md_go;
   logic                 md_is_div;
   rsp_type              res_in;
   logic                 out_free;
   logic                 rsp_valid_in;

   trc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_comb begin
      pc_cur = load_pend_ff ? ADDR_BITS'(start_pc_ff) : pc_ff;
      a_ok   = in_ff.op_a < 32'(NUM_REGS);
      b_ok   = in_ff.op_b < 32'(NUM_REGS);
      ra     = a_ok ? regs_ff[in_ff.op_a[REG_IDX_BITS-1:0]] : '0;
      rb     = b_ok ? regs_ff[in_ff.op_b[REG_IDX_BITS-1:0]] : '0;

      npc       = pc_cur + ADDR_BITS'(3);
      wr_en     = 1'b0;
      wr_data   = '0;
      cmp_wr    = 1'b0;
      md_go     = 1'b0;
      md_is_div = 1'b0;
      res_in    = '0;

      unique case (in_ff.func)
         OP_NOP: npc = pc_cur + ADDR_BITS'(1);
         OP_HALT: begin
            if (in_ff.resume) begin
               npc = pc_cur + ADDR_BITS'(1);
            end else begin
               npc           = pc_cur;
               res_in.halted = 1'b1;
            end
         end
         OP_MOV_RR: begin
            wr_en   = 1'b1;
            wr_data = rb;
         end
         OP_MOV_RM: begin
            wr_en   = 1'b1;
            wr_data = in_ff.mem_data;
         end
         OP_MOV_MR: begin
            res_in.mem_write  = 1'b1;
            res_in.write_addr = 16'(in_ff.op_a[ADDR_BITS-1:0]);
            res_in.write_data = rb;
         end
         OP_MOV_RI: begin
            wr_en   = 1'b1;
            wr_data = in_ff.op_b;
         end
         OP_MOV_MI: begin
            res_in.mem_write  = 1'b1;
            res_in.write_addr = 16'(in_ff.op_a[ADDR_BITS-1:0]);
            res_in.write_data = in_ff.op_b;
         end
         OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = ra + rb;
         end
         OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = ra - rb;
         end
         OP_CMP: begin
            cmp_wr  = 1'b1;
            wr_data = ra - rb;
         end
         OP_JMP: npc = in_ff.op_a[ADDR_BITS-1:0];
         OP_JZ, OP_JG, OP_JL: begin
            // jump taken lands at pc + 1 + offset, otherwise skip two words
            if ((in_ff.func == OP_JZ && cmp_ff == '0) ||
                (in_ff.func == OP_JG && cmp_ff != '0 && !cmp_ff[31]) ||
                (in_ff.func == OP_JL && cmp_ff[31])) begin
               npc = pc_cur + ADDR_BITS'(1) + in_ff.op_a[ADDR_BITS-1:0];
            end else begin
               npc = pc_cur + ADDR_BITS'(2);
            end
         end
         OP_OUT: begin
            if (in_ff.op_a <= OUT_MAX_REG) begin
               res_in.out_valid = 1'b1;
               res_in.out_reg   = in_ff.op_a[1:0];
               res_in.out_value = ra;
            end else begin
               res_in.fault = FAULT_OUT_REG;
            end
            npc = pc_cur + ADDR_BITS'(2);
         end
         OP_INC: begin
            wr_en   = 1'b1;
            wr_data = ra + 32'd1;
            npc     = pc_cur + ADDR_BITS'(2);
         end
         OP_DEC: begin
            wr_en   = 1'b1;
            wr_data = ra - 32'd1;
            npc     = pc_cur + ADDR_BITS'(2);
         end
         OP_MUL: md_go = 1'b1;
         OP_DIV: begin
            if (rb == '0) begin
               res_in.fault = FAULT_DIV0;
            end else begin
               md_go     = 1'b1;
               md_is_div = 1'b1;
            end
         end
         default: begin
            res_in.fault = FAULT_ILLEGAL;
            npc          = pc_cur;
         end
      endcase
      res_in.next_pc = 16'(npc);

      md_req.start  = (state_ff == ST_EXEC) && md_go;
      md_req.is_div = md_is_div;
      md_req.opnd_a = ra;
      md_req.opnd_b = rb;

      out_free = !rsp_valid_ff || rsp_ch.ready;
      // a new result loads, otherwise a transfer empties the output register
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         load_pend_ff <= 1'b1;
         start_pc_ff  <= '0;
         cmp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         if (csr_ch.valid) begin
            start_pc_ff <= csr_ch.data;
         end
         rsp_valid_ff <= rsp_valid_in;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  in_ff    <= req_ch.payload;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               pc_ff        <= npc;
               load_pend_ff <= 1'b0;
               res_ff       <= res_in;
               if (wr_en && a_ok) begin
                  regs_ff[in_ff.op_a[REG_IDX_BITS-1:0]] <= wr_data;
               end
               if (cmp_wr) begin
                  cmp_ff <= wr_data;
               end
               state_ff <= md_go ? ST_WAIT : ST_FINISH;
            end
            ST_WAIT: begin
               if (md_rsp.done) begin
                  if (a_ok) begin
                     regs_ff[in_ff.op_a[REG_IDX_BITS-1:0]] <= md_rsp.result;
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hand over once the output register is free
               if (out_free) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   a_req_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == ST_EXEC)
      else $error("request transfer did not enter execute");

   a_md_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> state_ff == ST_WAIT)
      else $error("multiply/divide finished outside wait state");

   a_cmp_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_EXEC |=> $stable(cmp_ff))
      else $error("compare flag changed outside execute");

   a_div0_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.fault == FAULT_DIV0
         |-> !rsp_data_ff.mem_write && !rsp_data_ff.out_valid)
      else $error("divide fault with side effects");

endmodule

/* dv/toy_register_cpu_execute_test.sv */
// ----------------------------------------------------------------------------
// toy_register_cpu_execute_test
// Self-checking bench for the register CPU execute stage. A queue of
// instructions feeds a valid/ready driver. Each accepted instruction runs
// through an in-bench model of the register file, compare flag and program
// counter. Every result is checked field by field against the oldest
// prediction. Directed corner cases come first, then random instruction
// streams, most with random gaps on both sides. The start address is rewritten
// between phases.
// ----------------------------------------------------------------------------
module toy_register_cpu_execute_test;
   import trc_pkg::*;

   localparam int IDLE_PCT     = 18;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset;

   trc_req_if req_ch ();
   trc_rsp_if rsp_ch ();
   trc_csr_if csr_ch ();

   toy_register_cpu_execute u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // architectural state of the modeled cpu
   logic [31:0] cpu_regs [NUM_REGS];
   logic [31:0] cmp_flag;
   logic [15:0] cur_pc;
   logic [15:0] start_addr;
   logic        pc_load_pending;

   req_type pending_instrs [$];
   rsp_type expected_results [$];

   int unsigned items_queued   = 0;
   int unsigned items_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned errors         = 0;
   int unsigned cycle_count    = 0;
   int unsigned csr_writes     = 0;
   int unsigned fault_count    = 0;
   int unsigned halt_count     = 0;
   int unsigned mem_writes     = 0;
   int unsigned out_count      = 0;
   int unsigned send_idle_pct  = IDLE_PCT;
   int unsigned recv_idle_pct  = IDLE_PCT;
   logic        req_taken      = 1'b0;

   function automatic logic [31:0] read_reg(input logic [31:0] idx);
      if (idx < NUM_REGS)
         return cpu_regs[idx[REG_IDX_BITS-1:0]];
      return 32'd0;
   endfunction

   function automatic void write_reg(input logic [31:0] idx, input logic [31:0] value);
      if (idx < NUM_REGS)
         cpu_regs[idx[REG_IDX_BITS-1:0]] = value;
   endfunction

   // truncating signed divide, most negative / -1 wraps
   function automatic logic [31:0] signed_quotient(input logic [31:0] n, input logic [31:0] d);
      logic [31:0] mag_n;
      logic [31:0] mag_d;
      logic [31:0] q;
      mag_n = n[31] ? 32'd0 - n : n;
      mag_d = d[31] ? 32'd0 - d : d;
      q = mag_n / mag_d;
      return (n[31] ^ d[31]) ? 32'd0 - q : q;
   endfunction

   function automatic rsp_type execute_instruction(input req_type ins);
      rsp_type     res;
      logic [15:0] pc;
      logic [31:0] va;
      logic [31:0] vb;
      logic        taken;
      res = '0;
      if (pc_load_pending) begin
         cur_pc = start_addr;
         pc_load_pending = 1'b0;
      end
      pc = cur_pc;
      va = read_reg(ins.op_a);
      vb = read_reg(ins.op_b);
      res.next_pc = pc + 16'd3;
      case (ins.func)
         OP_NOP: res.next_pc = pc + 16'd1;
         OP_HALT: begin
            if (ins.resume) begin
               res.next_pc = pc + 16'd1;
            end else begin
               res.next_pc = pc;
               res.halted = 1'b1;
            end
         end
         OP_MOV_RR: write_reg(ins.op_a, vb);
         OP_MOV_RM: write_reg(ins.op_a, ins.mem_data);
         OP_MOV_MR: begin
            res.mem_write  = 1'b1;
            res.write_addr = ins.op_a[15:0];
            res.write_data = vb;
         end
         OP_MOV_RI: write_reg(ins.op_a, ins.op_b);
         OP_MOV_MI: begin
            res.mem_write  = 1'b1;
            res.write_addr = ins.op_a[15:0];
            res.write_data = ins.op_b;
         end
         OP_ADD: write_reg(ins.op_a, va + vb);
         OP_SUB: write_reg(ins.op_a, va - vb);
         OP_CMP: cmp_flag = va - vb;
         OP_JMP: res.next_pc = ins.op_a[15:0];
         OP_JZ, OP_JG, OP_JL: begin
            case (ins.func)
               OP_JZ:   taken = (cmp_flag == 32'd0);
               OP_JG:   taken = (cmp_flag != 32'd0) && !cmp_flag[31];
               default: taken = cmp_flag[31];
            endcase
            res.next_pc = taken ? pc + 16'd1 + ins.op_a[15:0] : pc + 16'd2;
         end
         OP_OUT: begin
            if (ins.op_a <= OUT_MAX_REG) begin
               res.out_valid = 1'b1;
               res.out_reg   = ins.op_a[1:0];
               res.out_value = va;
            end else begin
               res.fault = FAULT_OUT_REG;
            end
            res.next_pc = pc + 16'd2;
         end
         OP_INC: begin
            write_reg(ins.op_a, va + 32'd1);
            res.next_pc = pc + 16'd2;
         end
         OP_DEC: begin
            write_reg(ins.op_a, va - 32'd1);
            res.next_pc = pc + 16'd2;
         end
         OP_MUL: write_reg(ins.op_a, va * vb);
         OP_DIV: begin
            if (vb == 32'd0)
               res.fault = FAULT_DIV0;
            else
               write_reg(ins.op_a, signed_quotient(va, vb));
         end
         default: begin
            res.fault = FAULT_ILLEGAL;
            res.next_pc = pc;
         end
      endcase
      cur_pc = res.next_pc;
      return res;
   endfunction

   // mostly valid register numbers, sometimes out of range
   function automatic logic [31:0] reg_index();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 85)
         return $urandom_range(0, 3);
      if (pick < 93)
         return $urandom_range(4, 15);
      return $urandom();
   endfunction

   function automatic logic [31:0] data_word();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return $urandom_range(0, 100);
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_instr();
      req_type ins;
      ins.func     = ($urandom_range(99) < 92) ? 5'($urandom_range(0, 18))
                                               : 5'($urandom_range(19, 31));
      ins.op_a     = reg_index();
      ins.op_b     = reg_index();
      ins.mem_data = data_word();
      ins.resume   = ($urandom_range(99) < 80);
      case (ins.func)
         OP_MOV_RI: ins.op_b = data_word();
         OP_MOV_RM: ins.op_b = $urandom();
         OP_MOV_MR: ins.op_a = $urandom();
         OP_MOV_MI: begin
            ins.op_a = $urandom();
            ins.op_b = data_word();
         end
         OP_JMP, OP_JZ, OP_JG, OP_JL: begin
            ins.op_a = $urandom_range(1) ? $urandom_range(0, 64) : $urandom();
         end
         default: ;
      endcase
      return ins;
   endfunction

   task automatic queue_instr(input logic [4:0] f, input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] md, input logic res);
      req_type ins;
      ins.func     = f;
      ins.op_a     = a;
      ins.op_b     = b;
      ins.mem_data = md;
      ins.resume   = res;
      pending_instrs.push_back(ins);
      items_queued++;
   endtask

   task automatic queue_random(input int unsigned count);
      req_type ins;
      repeat (count) begin
         ins = random_instr();
         queue_instr(ins.func, ins.op_a, ins.op_b, ins.mem_data, ins.resume);
      end
   endtask

   task automatic write_start_addr(input logic [15:0] addr);
      @(negedge clock);
      csr_ch.data  <= addr;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      start_addr = addr;
      csr_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (items_accepted != items_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: result %0d %s mismatch, expected %h, actual %h",
                  $time, results_seen, name, want, got);
         errors++;
      end
   endtask

   // instruction driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.payload <= pending_instrs.pop_front();
            req_ch.valid   <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // predict on every instruction transfer
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_results.push_back(execute_instruction(req_ch.payload));
         items_accepted++;
      end
   end

   // result monitor
   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("mem_write", want.mem_write, got.mem_write);
            compare_field("write_addr", want.write_addr, got.write_addr);
            compare_field("write_data", want.write_data, got.write_data);
            compare_field("out_valid", want.out_valid, got.out_valid);
            compare_field("out_reg", want.out_reg, got.out_reg);
            compare_field("out_value", want.out_value, got.out_value);
            compare_field("halted", want.halted, got.halted);
            compare_field("fault", want.fault, got.fault);
            if (want.fault != FAULT_NONE)
               fault_count++;
            halt_count += want.halted;
            mem_writes += want.mem_write;
            out_count  += want.out_valid;
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d of %0d instructions accepted, %0d results pending",
                  $time, items_accepted, items_queued, expected_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.data    = '0;
      for (int i = 0; i < NUM_REGS; i++)
         cpu_regs[i] = 32'd0;
      cmp_flag        = 32'd0;
      cur_pc          = 16'd0;
      start_addr      = 16'd0;
      pc_load_pending = 1'b1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // last write before the first instruction wins, top address wraps the pc
      write_start_addr(16'h0000);
      write_start_addr(16'hFFFF);

      queue_instr(OP_NOP, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_instr(OP_MOV_RI, 32'd0, 32'h7FFF_FFFF, 32'h0, 1'b1);
      queue_instr(OP_MOV_RI, 32'd1, 32'hFFFF_FFFF, 32'h0, 1'b1);
      queue_instr(OP_MOV_RI, 32'd2, 32'h8000_0000, 32'h0, 1'b1);
      queue_instr(OP_MOV_RM, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      queue_instr(OP_ADD, 32'd0, 32'd1, 32'h0, 1'b1);
      queue_instr(OP_DIV, 32'd2, 32'd1, 32'h0, 1'b1);
      // divisor register out of range reads as zero
      queue_instr(OP_DIV, 32'd0, 32'd7, 32'h0, 1'b1);
      queue_instr(OP_MUL, 32'd0, 32'd3, 32'h0, 1'b1);
      queue_instr(OP_CMP, 32'd2, 32'd2, 32'h0, 1'b1);
      queue_instr(OP_JZ, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
      queue_instr(OP_CMP, 32'd0, 32'd1, 32'h0, 1'b1);
      queue_instr(OP_JG, 32'd5, 32'h0, 32'h0, 1'b1);
      queue_instr(OP_CMP, 32'd2, 32'd0, 32'h0, 1'b1);
      queue_instr(OP_JL, 32'h10, 32'h0, 32'h0, 1'b1);
      queue_instr(OP_MOV_MR, 32'hFFFF_FFFF, 32'd0, 32'h0, 1'b1);
      queue_instr(OP_MOV_MI, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1);
      queue_instr(OP_OUT, 32'd3, 32'h0, 32'h0, 1'b1);
      queue_instr(OP_OUT, 32'd4, 32'h0, 32'h0, 1'b1);
      queue_instr(OP_OUT, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
      queue_instr(OP_INC, 32'd9, 32'h0, 32'h0, 1'b1);
      queue_instr(OP_HALT, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_instr(OP_HALT, 32'h0, 32'h0, 32'h0, 1'b1);
      queue_instr(5'd19, 32'h0, 32'h0, 32'h0, 1'b1);
      queue_instr(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      queue_instr(OP_JMP, 32'h0000_FFFF, 32'h0, 32'h0, 1'b1);
      wait_for_drain();

      write_start_addr(16'($urandom()));
      queue_random(450);
      wait_for_drain();

      // back-to-back stretch with no gaps on either side
      write_start_addr(16'h0000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(300);
      wait_for_drain();
      send_idle_pct = IDLE_PCT;
      recv_idle_pct = IDLE_PCT;

      write_start_addr(16'hFFFF);
      queue_random(500);
      wait_for_drain();

      $display("ran %0d instructions, %0d results checked, %0d start address writes",
               items_accepted, results_seen, csr_writes);
      $display("seen: %0d faults, %0d halts, %0d memory writes, %0d register displays",
               fault_count, halt_count, mem_writes, out_count);
      if (errors == 0 && expected_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
